/* hdl/bb3_pkg.sv */
package bb3_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Field and counter widths
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int OROW_W     = 12;
  localparam int CMP_W      = (COL_W + 1 > WID_W) ? COL_W + 1 : WID_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Datapath widths
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int CSUM_W = CH_W + 2;
  localparam int SUM_W  = CH_W + 4;
  localparam int CNT_W  = 4;
  localparam int X_W    = SUM_W + 1;
  localparam int RCP_W  = 16;
  localparam int PROD_W = X_W + RCP_W;

  // Input op codes
  localparam logic OP_PUSH = 1'b0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // Register reset values and clamp limits
  localparam logic [WID_W-1:0] W_RESET = WID_W'(640);
  localparam logic [WID_W-1:0] W_LIM   = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] H_RESET = HGT_W'(480);
  localparam logic [HGT_W-1:0] H_LIM   = HGT_W'(MAX_HEIGHT);

  // Pixel packed as blue in the low byte, red in the high byte
  typedef logic [PIX_W-1:0] pix_t;

  // One line buffer word: both stored rows of a column
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } lb_word_t;

  // Per-item control decided at acceptance
  typedef struct packed {
    logic emit;
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic last;
  } itm_flags_t;

  // Pipeline load strobes
  typedef struct packed {
    logic a_go;
    logic b_load;
    logic c_load;
    logic o_load;
  } pipe_en_t;

endpackage

/* hdl/bb3_line_buf.sv */
module bb3_line_buf import bb3_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  lb_word_t         wr_data,
  output lb_word_t         rd_data
);

  lb_word_t mem [MAX_WIDTH];
  lb_word_t rd_data_r;

  // Write port, registered read port with write-through on address match
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/bb3_ctrl.sv */
module bb3_ctrl import bb3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  acc,
  input  logic                  op,
  output itm_flags_t            flags,
  output logic                  pix_ok,
  output logic [COL_W-1:0]      rd_col
);

  logic [WID_W-1:0]  w_r, w_nxt;
  logic [HGT_W-1:0]  h_r, h_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [HGT_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;

  logic [CMP_W-1:0] w_ext, in_col_inc, out_col_inc;
  logic [HGT_W-1:0] out_row_inc;
  logic             in_wrap, out_wrap;

  function automatic logic [WID_W-1:0] clamp_w(input logic [WID_W-1:0] v);
    logic [WID_W-1:0] r;
    begin
      if (v == '0) begin
        r = WID_W'(1);
      end else if (v > W_LIM) begin
        r = W_LIM;
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

  function automatic logic [HGT_W-1:0] clamp_h(input logic [HGT_W-1:0] v);
    logic [HGT_W-1:0] r;
    begin
      if (v == '0) begin
        r = HGT_W'(1);
      end else if (v > H_LIM) begin
        r = H_LIM;
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

  // Position arithmetic
  assign w_ext       = CMP_W'(w_r);
  assign in_col_inc  = CMP_W'(in_col_r) + CMP_W'(1);
  assign out_col_inc = CMP_W'(out_col_r) + CMP_W'(1);
  assign out_row_inc = HGT_W'(out_row_r) + HGT_W'(1);
  assign in_wrap     = (in_col_inc == w_ext);
  assign out_wrap    = (out_col_inc == w_ext);

  // Item decisions: an output exists once one row and one pixel are in
  always_comb begin
    flags.emit   = (in_row_r > HGT_W'(1)) || ((in_row_r == HGT_W'(1)) && (in_col_r != '0));
    flags.left   = (out_col_r != '0);
    flags.right  = (out_col_inc < w_ext);
    flags.top    = (out_row_r != '0);
    flags.bottom = (out_row_inc < h_r);
    flags.last   = flags.emit && out_wrap && (out_row_inc == h_r);
  end

  // Pixels past the frame's end count as drain; drains inside it as black
  assign pix_ok = (op == OP_PUSH) && (in_row_r < h_r);
  assign rd_col = in_col_r;

  // Counter and register updates
  always_comb begin
    w_nxt       = w_r;
    h_nxt       = h_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (acc) begin
      if (in_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + HGT_W'(1);
      end else begin
        in_col_nxt = COL_W'(in_col_inc);
      end
      if (flags.emit) begin
        if (out_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OROW_W'(1);
        end else begin
          out_col_nxt = COL_W'(out_col_inc);
        end
      end
      if (flags.last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          w_nxt       = clamp_w(cfg_data[WID_W-1:0]);
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        REG_HEIGHT: begin
          h_nxt       = clamp_h(cfg_data[HGT_W-1:0]);
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= W_RESET;
      h_r       <= H_RESET;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

/* hdl/bb3_filter.sv */
module bb3_filter import bb3_pkg::*; (
  input  logic             clk,
  input  pipe_en_t         en,
  input  lb_word_t         lb_rd,
  input  pix_t             a_pix,
  input  itm_flags_t       a_flags,
  output logic [CH_W-1:0]  out_blue,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_red,
  output logic             out_last
);

  // Two most recent columns of the window (rows: upper, middle, bottom)
  pix_t win_a_r [3];
  pix_t win_b_r [3];
  pix_t new_col [3];

  // Stage B: masked column sums, per column and channel
  logic [2:0][2:0][CSUM_W-1:0] b_cs_r, b_cs_nxt;
  logic                        b_left_r, b_right_r, b_last_r;
  logic [CNT_W-1:0]            b_cnt_r, b_cnt_nxt;

  // Stage C: window sums
  logic [2:0][SUM_W-1:0] c_sum_r, c_sum_nxt;
  logic [CNT_W-1:0]      c_cnt_r;
  logic                  c_last_r;

  // Output register
  logic [2:0][CH_W-1:0] o_ch_r, o_ch_nxt;
  logic                 o_last_r;

  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] c);
    logic [RCP_W-1:0] m;
    begin
      // ceil(2^16 / (2*count)); exact enough for every reachable sum
      unique case (c)
        CNT_W'(1): m = RCP_W'(32768);
        CNT_W'(2): m = RCP_W'(16384);
        CNT_W'(3): m = RCP_W'(10923);
        CNT_W'(4): m = RCP_W'(8192);
        CNT_W'(6): m = RCP_W'(5462);
        CNT_W'(9): m = RCP_W'(3641);
        default:   m = RCP_W'(32768);
      endcase
      return m;
    end
  endfunction

  assign new_col[0] = lb_rd.upper;
  assign new_col[1] = lb_rd.middle;
  assign new_col[2] = a_pix;

  // Column sums of the shifted window, top and bottom rows masked
  always_comb begin
    logic [1:0] cols, rows;
    for (int ch = 0; ch < 3; ch++) begin
      b_cs_nxt[0][ch] = (a_flags.top ? CSUM_W'(win_a_r[0][ch*CH_W +: CH_W]) : '0)
                      + CSUM_W'(win_a_r[1][ch*CH_W +: CH_W])
                      + (a_flags.bottom ? CSUM_W'(win_a_r[2][ch*CH_W +: CH_W]) : '0);
      b_cs_nxt[1][ch] = (a_flags.top ? CSUM_W'(win_b_r[0][ch*CH_W +: CH_W]) : '0)
                      + CSUM_W'(win_b_r[1][ch*CH_W +: CH_W])
                      + (a_flags.bottom ? CSUM_W'(win_b_r[2][ch*CH_W +: CH_W]) : '0);
      b_cs_nxt[2][ch] = (a_flags.top ? CSUM_W'(new_col[0][ch*CH_W +: CH_W]) : '0)
                      + CSUM_W'(new_col[1][ch*CH_W +: CH_W])
                      + (a_flags.bottom ? CSUM_W'(new_col[2][ch*CH_W +: CH_W]) : '0);
    end
    cols      = 2'd1 + {1'b0, a_flags.left} + {1'b0, a_flags.right};
    rows      = 2'd1 + {1'b0, a_flags.top} + {1'b0, a_flags.bottom};
    b_cnt_nxt = {2'b00, cols} * {2'b00, rows};
  end

  // Window sums, left and right columns masked
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      c_sum_nxt[ch] = (b_left_r ? SUM_W'(b_cs_r[0][ch]) : '0)
                    + SUM_W'(b_cs_r[1][ch])
                    + (b_right_r ? SUM_W'(b_cs_r[2][ch]) : '0);
    end
  end

  // Rounded average: floor((2*sum + count) / (2*count)) by reciprocal
  always_comb begin
    logic [X_W-1:0]    x;
    logic [PROD_W-1:0] prod;
    for (int ch = 0; ch < 3; ch++) begin
      x            = {c_sum_r[ch], 1'b0} + X_W'(c_cnt_r);
      prod         = PROD_W'(x) * PROD_W'(recip(c_cnt_r));
      o_ch_nxt[ch] = prod[RCP_W +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en.a_go) begin
      for (int k = 0; k < 3; k++) begin
        win_a_r[k] <= win_b_r[k];
        win_b_r[k] <= new_col[k];
      end
    end
    if (en.b_load) begin
      b_cs_r    <= b_cs_nxt;
      b_left_r  <= a_flags.left;
      b_right_r <= a_flags.right;
      b_last_r  <= a_flags.last;
      b_cnt_r   <= b_cnt_nxt;
    end
    if (en.c_load) begin
      c_sum_r  <= c_sum_nxt;
      c_cnt_r  <= b_cnt_r;
      c_last_r <= b_last_r;
    end
    if (en.o_load) begin
      o_ch_r   <= o_ch_nxt;
      o_last_r <= c_last_r;
    end
  end

  assign out_blue  = o_ch_r[0];
  assign out_green = o_ch_r[1];
  assign out_red   = o_ch_r[2];
  assign out_last  = o_last_r;

endmodule

/* hdl/box_blur_3x3_rgb_unit.sv */
// 3x3 box blur on an RGB raster stream. One transaction is accepted per clock
// while the output is not stalled, and at most one blurred pixel leaves per
// transaction; after input transaction n (pixel pushes, then drain transactions)
// output pixel n-(W+1) is produced, so W+1 drains flush a frame. The result is
// registered through a four register pipeline: input register with the line
// buffer read, masked column sums, window sum, and the reciprocal divide into the
// output register. Two rows are held in one MAX_WIDTH x 48 bit line buffer RAM;
// its single read and single write a clock keep the rate at one pixel per clock
// when the output is not stalled. Width and height registers are clamped to
// 1..MAX_WIDTH and 1..4096, and writing either one restarts the frame; write
// them only while the block is idle.
module box_blur_3x3_rgb_unit import bb3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [CH_W-1:0]       in_blue,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_red,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_blue,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_red,
  output logic                  out_last_of_frame
);

  logic             acc;
  itm_flags_t       flags;
  logic             pix_ok;
  logic [COL_W-1:0] rd_col;
  lb_word_t         lb_rd, lb_wr;
  pipe_en_t         en;

  // Stage A holds the accepted transaction
  logic             a_vld_r, a_vld_nxt;
  itm_flags_t       a_flags_r;
  pix_t             a_pix_r;
  logic [COL_W-1:0] a_col_r;

  logic b_vld_r, b_vld_nxt;
  logic c_vld_r, c_vld_nxt;
  logic out_vld_r, out_vld_nxt;

  logic out_free, c_free, b_free;
  logic a_go, b_go, c_go;

  // Stall chain; items that produce no output drop out after the window shift
  assign out_free = !out_vld_r || out_ready;
  assign c_go     = c_vld_r && out_free;
  assign c_free   = !c_vld_r || out_free;
  assign b_go     = b_vld_r && c_free;
  assign b_free   = !b_vld_r || c_free;
  assign a_go     = a_vld_r && (!a_flags_r.emit || b_free);
  assign in_ready = !a_vld_r || a_go;
  assign acc      = in_valid && in_ready;

  assign en.a_go   = a_go;
  assign en.b_load = a_go && a_flags_r.emit;
  assign en.c_load = b_go;
  assign en.o_load = c_go;

  always_comb begin
    a_vld_nxt   = acc ? 1'b1 : (a_go ? 1'b0 : a_vld_r);
    b_vld_nxt   = en.b_load ? 1'b1 : (b_go ? 1'b0 : b_vld_r);
    c_vld_nxt   = b_go ? 1'b1 : (c_go ? 1'b0 : c_vld_r);
    out_vld_nxt = c_go ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      a_vld_r   <= a_vld_nxt;
      b_vld_r   <= b_vld_nxt;
      c_vld_r   <= c_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Stage A payload
  always_ff @(posedge clk) begin
    if (acc) begin
      a_flags_r <= flags;
      a_pix_r   <= pix_ok ? {in_red, in_green, in_blue} : '0;
      a_col_r   <= rd_col;
    end
  end

  bb3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .op        (in_op),
    .flags     (flags),
    .pix_ok    (pix_ok),
    .rd_col    (rd_col)
  );

  // Column moves up one row as it leaves stage A
  assign lb_wr.upper  = lb_rd.middle;
  assign lb_wr.middle = a_pix_r;

  bb3_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (rd_col),
    .wr_en   (a_go),
    .wr_addr (a_col_r),
    .wr_data (lb_wr),
    .rd_data (lb_rd)
  );

  bb3_filter u_filter (
    .clk       (clk),
    .en        (en),
    .lb_rd     (lb_rd),
    .a_pix     (a_pix_r),
    .a_flags   (a_flags_r),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .out_last  (out_last_of_frame)
  );

  assign out_valid = out_vld_r;

`ifndef NO_ASSERTIONS
  // A held transaction in stage A blocks acceptance
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && !a_go) |-> !in_ready)
    else $error("transaction accepted while stage A is stalled");

  // A finished window sum reaches the output register when it is free
  c_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (c_vld_r && out_free) |=> out_valid)
    else $error("window sum lost before output register");

  // A transaction without output never occupies stage B
  no_emit_skips_b: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && !a_flags_r.emit && !b_go) |=> (b_vld_r == $past(b_vld_r)))
    else $error("stage B changed by a transaction without output");
`endif

endmodule
